// File: hw/rtl/ir_eic_pkg.sv
// Shared types and constants for the infrared edge interval capture block.
// Used by ir_eic_ctrl, ir_eic_store and ir_edge_interval_capture.
`default_nettype none

package ir_eic_pkg;

   // Default size of the capture buffer in bytes
   localparam int STORE_BYTES_DEF = 192;

   // Largest byte count that may still take another interval
   localparam logic [7:0] BYTE_COUNT_MAX = 8'd253;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GLITCH_LOW   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_GAP_HIGH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STARTUP      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_TIMEOUT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_VALID    = 3'd4;

   // Configuration reset values
   localparam logic [7:0] GLITCH_LOW_RESET   = 8'h40;
   localparam logic [6:0] END_GAP_HIGH_RESET = 7'h10;
   localparam logic [7:0] STARTUP_RESET      = 8'd16;
   localparam logic [7:0] IDLE_TIMEOUT_RESET = 8'd250;
   localparam logic [7:0] MIN_VALID_RESET    = 8'd4;

   typedef enum logic [1:0] {
      CMD_ARM  = 2'd0,
      CMD_EDGE = 2'd1,
      CMD_TICK = 2'd2,
      CMD_READ = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_NONE     = 2'd0,
      ST_COMPLETE = 2'd1,
      ST_FAIL     = 2'd2,
      ST_READ     = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type     command;
      logic [14:0] interval_ticks;
      logic [7:0]  read_index;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [7:0] record_len;
      logic [7:0] data_byte;
   } rsp_type;

   // Buffer access controls from the sequencer to the store
   typedef struct packed {
      logic wr_en;   // write high byte and low byte of one interval
      logic rd_en;   // capture read side for the beat being issued
      logic rd_odd;  // byte sits in the low-byte bank
      logic rd_hit;  // read offset falls inside the buffer
   } mem_ctl_type;

endpackage

`default_nettype wire

// File: hw/rtl/ir_eic_store.sv
// Capture buffer: two byte banks, even offsets hold high bytes, odd hold low bytes.
// Depends on ir_eic_pkg for the access control struct.
`default_nettype none

module ir_eic_store #(
   parameter int STORE_BYTES = ir_eic_pkg::STORE_BYTES_DEF,
   localparam int BANK_DEPTH = (STORE_BYTES + 1) / 2,
   localparam int ADDR_W = $clog2(BANK_DEPTH)
) (
   input  wire logic                    clock,
   input  wire ir_eic_pkg::mem_ctl_type mem_ctl,
   input  wire logic [ADDR_W-1:0]       wr_addr,
   input  wire logic [7:0]              wr_hi,
   input  wire logic [7:0]              wr_lo,
   input  wire logic [ADDR_W-1:0]       rd_addr,
   output logic [7:0]                   rd_data
);

   logic [7:0] even_mem [BANK_DEPTH];
   logic [7:0] odd_mem  [BANK_DEPTH];

   logic [7:0] even_q_ff;
   logic [7:0] odd_q_ff;
   logic       rd_odd_ff;
   logic       rd_hit_ff;

   // Both bytes of an interval land in the same cycle, one per bank
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         even_mem[wr_addr] <= wr_hi;
         odd_mem[wr_addr]  <= wr_lo;
      end
   end

   // Registered read, held while the result beat waits
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         even_q_ff <= even_mem[rd_addr];
         odd_q_ff  <= odd_mem[rd_addr];
         rd_odd_ff <= mem_ctl.rd_odd;
         rd_hit_ff <= mem_ctl.rd_hit;
      end
   end

   // Out-of-range and non-read beats return zero
   always_comb begin
      if (!rd_hit_ff) begin
         rd_data = 8'h00;
      end else if (rd_odd_ff) begin
         rd_data = odd_q_ff;
      end else begin
         rd_data = even_q_ff;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/ir_eic_ctrl.sv
// Capture sequencer: configuration registers, capture state, buffer access
// and the result register. Depends on ir_eic_pkg.
`default_nettype none

module ir_eic_ctrl #(
   parameter int STORE_BYTES = ir_eic_pkg::STORE_BYTES_DEF,
   localparam int BANK_DEPTH = (STORE_BYTES + 1) / 2,
   localparam int ADDR_W = $clog2(BANK_DEPTH)
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               accept,
   input  wire ir_eic_pkg::req_type                req,
   input  wire logic                               rsp_stall,
   input  wire logic                               csr_wr_en,
   input  wire logic [ir_eic_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                         csr_wr_data,
   output logic                                    rsp_valid,
   output ir_eic_pkg::status_type                  rsp_status,
   output logic [7:0]                              rsp_length,
   output ir_eic_pkg::mem_ctl_type                 mem_ctl,
   output logic [ADDR_W-1:0]                       wr_addr,
   output logic [7:0]                              wr_hi,
   output logic [7:0]                              wr_lo,
   output logic [ADDR_W-1:0]                       rd_addr
);

   localparam logic [8:0] STORE_LIM = 9'(STORE_BYTES);

   // Configuration
   logic [7:0] glitch_low_ff;
   logic [6:0] end_gap_high_ff;
   logic [7:0] startup_ff;
   logic [7:0] idle_timeout_ff;
   logic [7:0] min_valid_ff;

   // Capture state
   logic       active_ff, active_in;
   logic [7:0] bc_ff, bc_in;
   logic [7:0] idle_ff, idle_in;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   ir_eic_pkg::status_type status_ff, status_in;
   logic [7:0]             length_ff, length_in;

   // Decoded item terms
   logic [6:0] hi;
   logic [7:0] lo;
   logic       store_full;
   logic       glitch;
   logic       gap_end;
   logic       finish_ok;
   logic [7:0] idle_next;
   logic [8:0] rd_pos;
   logic       rd_hit;

   assign hi         = req.interval_ticks[14:8];
   assign lo         = req.interval_ticks[7:0];
   assign store_full = (({1'b0, bc_ff} + 9'd2) > STORE_LIM) ||
                       (bc_ff > ir_eic_pkg::BYTE_COUNT_MAX);
   assign glitch     = (hi == 7'd0) && (lo < glitch_low_ff);
   // A glitch restarts the count rather than ending the capture on a gap
   assign gap_end    = !glitch && (bc_ff > startup_ff) && (hi > end_gap_high_ff);
   assign finish_ok  = bc_ff > min_valid_ff;
   assign idle_next  = (idle_ff == 8'hFF) ? idle_ff : idle_ff + 8'd1;
   assign rd_pos     = {1'b0, req.read_index} + 9'd2;
   assign rd_hit     = rd_pos < STORE_LIM;

   // Buffer write side: count is always even, so it addresses a bank row
   assign wr_addr = bc_ff[ADDR_W:1];
   assign wr_hi   = {1'b0, hi};
   assign wr_lo   = lo;
   assign rd_addr = rd_hit ? rd_pos[ADDR_W:1] : '0;

   // Next state for one beat
   always_comb begin
      active_in    = active_ff;
      bc_in        = bc_ff;
      idle_in      = idle_ff;
      status_in    = status_ff;
      length_in    = length_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_ctl      = '0;
      if (accept) begin
         rsp_valid_in   = 1'b1;
         status_in      = ir_eic_pkg::ST_NONE;
         length_in      = 8'd0;
         mem_ctl.rd_en  = 1'b1;
         mem_ctl.rd_odd = rd_pos[0];
         case (req.command)
            ir_eic_pkg::CMD_ARM: begin
               active_in = 1'b1;
               bc_in     = 8'd0;
               idle_in   = 8'd0;
            end
            ir_eic_pkg::CMD_EDGE: begin
               if (active_ff) begin
                  if (store_full) begin
                     active_in = 1'b0;
                     status_in = ir_eic_pkg::ST_FAIL;
                  end else begin
                     mem_ctl.wr_en = 1'b1;
                     if (gap_end) begin
                        active_in = 1'b0;
                        if (finish_ok) begin
                           status_in = ir_eic_pkg::ST_COMPLETE;
                           length_in = bc_ff - 8'd1;
                        end else begin
                           status_in = ir_eic_pkg::ST_FAIL;
                        end
                     end else if (glitch) begin
                        bc_in = 8'd2;
                     end else begin
                        bc_in = bc_ff + 8'd2;
                     end
                  end
               end
            end
            ir_eic_pkg::CMD_TICK: begin
               if (active_ff) begin
                  if (bc_ff != 8'd0) begin
                     active_in = 1'b0;
                     if (finish_ok) begin
                        status_in = ir_eic_pkg::ST_COMPLETE;
                        length_in = bc_ff - 8'd1;
                     end else begin
                        status_in = ir_eic_pkg::ST_FAIL;
                     end
                  end else begin
                     idle_in = idle_next;
                     if (idle_next > idle_timeout_ff) begin
                        active_in = 1'b0;
                        status_in = ir_eic_pkg::ST_FAIL;
                     end
                  end
               end
            end
            ir_eic_pkg::CMD_READ: begin
               status_in      = ir_eic_pkg::ST_READ;
               mem_ctl.rd_hit = rd_hit;
            end
            default: begin
               status_in = ir_eic_pkg::ST_NONE;
            end
         endcase
      end
   end

   // State and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         bc_ff        <= 8'd0;
         idle_ff      <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         bc_ff        <= bc_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      length_ff <= length_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         glitch_low_ff   <= ir_eic_pkg::GLITCH_LOW_RESET;
         end_gap_high_ff <= ir_eic_pkg::END_GAP_HIGH_RESET;
         startup_ff      <= ir_eic_pkg::STARTUP_RESET;
         idle_timeout_ff <= ir_eic_pkg::IDLE_TIMEOUT_RESET;
         min_valid_ff    <= ir_eic_pkg::MIN_VALID_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            ir_eic_pkg::CSR_GLITCH_LOW:   glitch_low_ff   <= csr_wr_data;
            ir_eic_pkg::CSR_END_GAP_HIGH: end_gap_high_ff <= csr_wr_data[6:0];
            ir_eic_pkg::CSR_STARTUP:      startup_ff      <= csr_wr_data;
            ir_eic_pkg::CSR_IDLE_TIMEOUT: idle_timeout_ff <= csr_wr_data;
            ir_eic_pkg::CSR_MIN_VALID:    min_valid_ff    <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_length = length_ff;

endmodule

`default_nettype wire

// File: hw/rtl/ir_edge_interval_capture.sv
// Infrared edge interval capture, top level.
// Instantiates ir_eic_ctrl and ir_eic_store; types from ir_eic_pkg.
//
// Usage:
//   req_* channel carries one command beat: arm, edge (15-bit interval),
//   timer overflow tick, or read of one buffered byte. Every accepted beat
//   produces exactly one rsp_* beat with a status, the signal length on
//   completion, and the byte on reads.
//   csr_* is a write-only port for the five capture thresholds; write it only
//   while no beat is in flight.
// Timing:
//   A response appears in the cycle after its request is accepted. The block
//   takes one beat per cycle unless a stalled response holds it off. The
//   buffer is two byte banks (high/low byte of each interval), each with one
//   write and one registered read, so an edge stores both in the same cycle.
// Stall:
//   The response sits in an output register. While rsp_stall holds it,
//   req_stall is raised and nothing new is taken; otherwise a new request
//   is taken in the same cycle the old response leaves.
// Reset:
//   Synchronous, active high. Capture goes idle, counts clear, thresholds
//   return to defaults. The buffer is not cleared and needs no start-up pass.
`default_nettype none

module ir_edge_interval_capture #(
   parameter int STORE_BYTES = ir_eic_pkg::STORE_BYTES_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire ir_eic_pkg::req_type                req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output ir_eic_pkg::rsp_type                     rsp_data,
   input  wire logic                               csr_wr_en,
   input  wire logic [ir_eic_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                         csr_wr_data
);

   localparam int BANK_DEPTH = (STORE_BYTES + 1) / 2;
   localparam int ADDR_W = $clog2(BANK_DEPTH);

   logic                    req_accept;
   ir_eic_pkg::mem_ctl_type mem_ctl;
   logic [ADDR_W-1:0]       wr_addr;
   logic [ADDR_W-1:0]       rd_addr;
   logic [7:0]              wr_hi;
   logic [7:0]              wr_lo;
   logic [7:0]              rd_data;
   ir_eic_pkg::status_type  rsp_status;
   logic [7:0]              rsp_length;

   // Hold off new beats only while a response is stuck
   assign req_stall  = rsp_valid && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   ir_eic_ctrl #(
      .STORE_BYTES (STORE_BYTES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .req         (req_data),
      .rsp_stall   (rsp_stall),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_status  (rsp_status),
      .rsp_length  (rsp_length),
      .mem_ctl     (mem_ctl),
      .wr_addr     (wr_addr),
      .wr_hi       (wr_hi),
      .wr_lo       (wr_lo),
      .rd_addr     (rd_addr)
   );

   ir_eic_store #(
      .STORE_BYTES (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_hi   (wr_hi),
      .wr_lo   (wr_lo),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Response beat
   always_comb begin
      rsp_data.status     = rsp_status;
      rsp_data.record_len = rsp_length;
      rsp_data.data_byte  = rd_data;
   end

   // A stalled request always means a response is pending
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response pending");

   // Every read beat answers with read status on the next cycle
   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.command == ir_eic_pkg::CMD_READ)
      |=> (rsp_valid && rsp_data.status == ir_eic_pkg::ST_READ))
      else $error("read beat did not return read status");

   // Only read responses carry a data byte
   a_data_only_on_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ir_eic_pkg::ST_READ)
      |-> (rsp_data.data_byte == 8'h00))
      else $error("data byte set on a non-read response");

   // Only completions carry a length
   a_length_only_on_complete: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ir_eic_pkg::ST_COMPLETE)
      |-> (rsp_data.record_len == 8'd0))
      else $error("signal length set on a non-completion response");

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for ir_edge_interval_capture: drives command beats, predicts
// every response beat from its own capture model and compares field by field.
// Depends on ir_eic_pkg and the ir_edge_interval_capture top level only.
`default_nettype none

module testbench;
   import ir_eic_pkg::*;

   localparam int STORE_BYTES = STORE_BYTES_DEF;

   typedef struct {
      req_type req;
      rsp_type rsp;
   } beat_type;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   req_type                req_data    = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = CSR_GLITCH_LOW;
   logic [7:0]             csr_wr_data = '0;

   // Capture model state and thresholds
   logic [7:0]  store_mem [STORE_BYTES];
   bit          written [STORE_BYTES];
   bit          cap_on;
   int unsigned nbytes;
   int unsigned idle_ticks;
   logic [7:0]  cfg_glitch;
   logic [6:0]  cfg_gap;
   logic [7:0]  cfg_startup;
   logic [7:0]  cfg_idle;
   logic [7:0]  cfg_min;

   // Beats waiting to be driven, and responses owed by the block
   beat_type    pending_beats[$];
   rsp_type     owed_rsp[$];
   rsp_type     cur_rsp = '0;

   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int          fails         = 0;
   int          live_beats    = 0;

   ir_edge_interval_capture #(
      .STORE_BYTES (STORE_BYTES)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

   // ---------------------------------------------------------------- model

   task automatic model_reset();
      cfg_glitch  = GLITCH_LOW_RESET;
      cfg_gap     = END_GAP_HIGH_RESET;
      cfg_startup = STARTUP_RESET;
      cfg_idle    = IDLE_TIMEOUT_RESET;
      cfg_min     = MIN_VALID_RESET;
      cap_on      = 1'b0;
      nbytes      = 0;
      idle_ticks  = 0;
      for (int i = 0; i < STORE_BYTES; i++) begin
         store_mem[i] = '0;
         written[i]   = 1'b0;
      end
   endtask

   // Capture ends: valid only with enough bytes stored
   function automatic rsp_type close_capture();
      rsp_type o;
      o = '0;
      cap_on = 1'b0;
      if (nbytes > cfg_min) begin
         o.status     = ST_COMPLETE;
         o.record_len = 8'(nbytes - 1);
      end else begin
         o.status = ST_FAIL;
      end
      return o;
   endfunction

   function automatic rsp_type capture_step(req_type r);
      rsp_type     o;
      logic [6:0]  hi;
      logic [7:0]  lo;
      int unsigned pos;
      o  = '0;
      hi = r.interval_ticks[14:8];
      lo = r.interval_ticks[7:0];
      case (r.command)
         CMD_ARM: begin
            cap_on     = 1'b1;
            nbytes     = 0;
            idle_ticks = 0;
         end
         CMD_EDGE: begin
            if (cap_on) begin
               if (nbytes + 2 > STORE_BYTES || nbytes > BYTE_COUNT_MAX) begin
                  cap_on   = 1'b0;
                  o.status = ST_FAIL;
               end else begin
                  store_mem[nbytes]     = {1'b0, hi};
                  store_mem[nbytes + 1] = lo;
                  written[nbytes]       = 1'b1;
                  written[nbytes + 1]   = 1'b1;
                  // short glitch restarts the record, old bytes stay put
                  if (lo < cfg_glitch && hi == 7'd0)
                     nbytes = 0;
                  if (nbytes > cfg_startup && store_mem[nbytes] > {1'b0, cfg_gap})
                     o = close_capture();
                  else
                     nbytes += 2;
               end
            end
         end
         CMD_TICK: begin
            if (cap_on) begin
               if (nbytes != 0) begin
                  o = close_capture();
               end else begin
                  if (idle_ticks < 255)
                     idle_ticks++;
                  if (idle_ticks > cfg_idle) begin
                     cap_on   = 1'b0;
                     o.status = ST_FAIL;
                  end
               end
            end
         end
         CMD_READ: begin
            o.status = ST_READ;
            pos      = 2 + r.read_index;
            if (pos < STORE_BYTES)
               o.data_byte = store_mem[pos];
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   // ------------------------------------------------------------- stimulus

   // Queue one beat with its predicted response
   task automatic send_beat(cmd_type c, logic [14:0] ticks, logic [7:0] idx);
      beat_type b;
      if (cap_on || c == CMD_ARM || c == CMD_READ)
         live_beats++;
      b.req.command        = c;
      b.req.interval_ticks = ticks;
      b.req.read_index     = idx;
      b.rsp                = capture_step(b.req);
      pending_beats.push_back(b);
   endtask

   // Read a byte that has been written; skipped if none is found
   task automatic send_read();
      int p;
      for (int k = 0; k < 16; k++) begin
         p = $urandom_range(2, STORE_BYTES - 1);
         if (written[p]) begin
            send_beat(CMD_READ, 15'($urandom_range(0, 32767)), 8'(p - 2));
            return;
         end
      end
   endtask

   function automatic logic [14:0] pick_interval();
      case ($urandom_range(0, 9))
         0:       return {7'd0, 8'($urandom_range(0, 255))};
         1:       return 15'($urandom_range(0, 32767));
         default: return {7'($urandom_range(0, cfg_gap)), 8'($urandom_range(0, 255))};
      endcase
   endfunction

   task automatic send_edge(logic [14:0] ticks);
      send_beat(CMD_EDGE, ticks, 8'($urandom_range(0, 189)));
   endtask

   task automatic send_cmd(cmd_type c);
      send_beat(c, 15'($urandom_range(0, 32767)), 8'($urandom_range(0, 189)));
   endtask

   // Wait until every beat is out and every response is back
   task automatic drain();
      while (pending_beats.size() != 0 || req_valid || owed_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Program all five thresholds while the block is idle
   task automatic set_config(logic [7:0] g, logic [6:0] e, logic [7:0] s,
                             logic [7:0] i, logic [7:0] m);
      drain();
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_GLITCH_LOW;
      csr_wr_data <= g;
      @(posedge clock);
      csr_index   <= CSR_END_GAP_HIGH;
      csr_wr_data <= {1'b0, e};
      @(posedge clock);
      csr_index   <= CSR_STARTUP;
      csr_wr_data <= s;
      @(posedge clock);
      csr_index   <= CSR_IDLE_TIMEOUT;
      csr_wr_data <= i;
      @(posedge clock);
      csr_index   <= CSR_MIN_VALID;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cfg_glitch  = g;
      cfg_gap     = e;
      cfg_startup = s;
      cfg_idle    = i;
      cfg_min     = m;
   endtask

   // ---------------------------------------------------------------- tests

   // Reset thresholds: idle items, glitches, gap end, tick end, re-arm
   task automatic test_directed();
      send_cmd(CMD_TICK);
      send_edge(15'h0123);
      send_cmd(CMD_ARM);
      send_edge(15'h0000);
      send_edge(15'h7FFF);
      send_edge(15'h00FF);
      send_edge(15'h0040);
      send_edge(15'h003F);
      send_beat(CMD_READ, 15'h7FFF, 8'd0);
      for (int k = 0; k < 8; k++)
         send_edge(15'h1000 + 15'(k * 17));
      send_edge(15'h1100);
      send_beat(CMD_READ, 15'h0000, 8'd15);
      send_cmd(CMD_ARM);
      send_edge(15'h0100);
      send_cmd(CMD_TICK);
      send_cmd(CMD_ARM);
      send_cmd(CMD_ARM);
      send_cmd(CMD_TICK);
      send_edge(15'h0A55);
      send_cmd(CMD_TICK);
      drain();
   endtask

   // Empty capture running out of timer overflows, including saturation
   task automatic test_idle_timeout();
      set_config(GLITCH_LOW_RESET, END_GAP_HIGH_RESET, STARTUP_RESET, 8'd0,
                 MIN_VALID_RESET);
      send_cmd(CMD_ARM);
      send_cmd(CMD_TICK);
      send_cmd(CMD_TICK);
      set_config(GLITCH_LOW_RESET, END_GAP_HIGH_RESET, STARTUP_RESET, 8'd3,
                 MIN_VALID_RESET);
      send_cmd(CMD_ARM);
      repeat (4) send_cmd(CMD_TICK);
      set_config(GLITCH_LOW_RESET, END_GAP_HIGH_RESET, STARTUP_RESET, 8'd255,
                 MIN_VALID_RESET);
      send_cmd(CMD_ARM);
      repeat (260) send_cmd(CMD_TICK);
      send_edge(15'h0200);
      send_cmd(CMD_TICK);
   endtask

   // Fill the whole buffer: one more edge fails, a full record completes
   task automatic test_store_overflow();
      set_config(8'd0, 7'd127, 8'd191, IDLE_TIMEOUT_RESET, 8'd191);
      send_cmd(CMD_ARM);
      repeat (STORE_BYTES / 2 + 1) send_edge(15'($urandom_range(0, 32767)));
      send_beat(CMD_READ, 15'h0000, 8'd189);
      send_beat(CMD_READ, 15'h7FFF, 8'd128);
      send_cmd(CMD_ARM);
      repeat (STORE_BYTES / 2) send_edge(15'($urandom_range(0, 32767)));
      send_cmd(CMD_TICK);
      repeat (8) send_read();
   endtask

   // One armed capture with random content, then reads and some noise
   task automatic send_capture();
      int len;
      cmd_type c;
      send_cmd(CMD_ARM);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 100) : $urandom_range(0, 20);
      for (int k = 0; k < len; k++)
         send_edge(pick_interval());
      if ($urandom_range(0, 1) == 1)
         send_cmd(CMD_TICK);
      repeat ($urandom_range(0, 3)) send_read();
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 4)) begin
            c = cmd_type'($urandom_range(0, 3));
            if (c == CMD_READ)
               send_read();
            else
               send_beat(c, 15'($urandom_range(0, 32767)), 8'($urandom_range(0, 189)));
         end
      end
   endtask

   task automatic test_random();
      int target;
      for (int round = 0; round < 6; round++) begin
         case (round)
            0: set_config(GLITCH_LOW_RESET, END_GAP_HIGH_RESET, STARTUP_RESET,
                          IDLE_TIMEOUT_RESET, MIN_VALID_RESET);
            1: set_config(8'd255, 7'd127, 8'd191, 8'd255, 8'd191);
            2: set_config(8'd0, 7'd0, 8'd0, 8'd0, 8'd0);
            default: set_config(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                                8'($urandom_range(0, 191)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 191)));
         endcase
         // idle mix for this round
         case (round % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 78; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 78; end
            default: begin send_idle_pct = 23; stall_pct = 23; end
         endcase
         target = live_beats + 170;
         while (live_beats < target)
            send_capture();
      end
   endtask

   // --------------------------------------------------------------- driving

   // Present the next beat once the current one is taken; hold it while stalled
   always @(posedge clock) begin : drive_req
      beat_type nxt;
      if (!reset) begin
         if (req_valid && !req_stall)
            owed_rsp.push_back(cur_rsp);
         if (!req_valid || !req_stall) begin
            if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt        = pending_beats.pop_front();
               req_data  <= nxt.req;
               cur_rsp   <= nxt.rsp;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Random back-pressure on the response side
   always @(posedge clock)
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   // --------------------------------------------------------------- checking

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_rsp.size() == 0) begin
            $error("unexpected response beat: status %0d", rsp_data.status);
            fails++;
         end else begin
            want = owed_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               fails++;
            end
            if (rsp_data.record_len !== want.record_len) begin
               $error("record_len: expected %0d, actual %0d",
                      want.record_len, rsp_data.record_len);
               fails++;
            end
            if (rsp_data.data_byte !== want.data_byte) begin
               $error("data_byte: expected %0d, actual %0d",
                      want.data_byte, rsp_data.data_byte);
               fails++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- main

   initial begin
      model_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_idle_timeout();
      test_store_overflow();
      test_random();
      drain();
      if (fails == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/ir_eic_pkg.sv
hw/rtl/ir_eic_store.sv
hw/rtl/ir_eic_ctrl.sv
hw/rtl/ir_edge_interval_capture.sv
verif/testbench.sv
